// ----- hdl/gn2d_pkg.sv -----
package gn2d_pkg;

    // request kinds on the input channel
    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } op_t;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_GRID_W = 1'b0,
        REG_GRID_H = 1'b1
    } reg_idx_t;

    localparam int CFG_W       = 7;
    localparam int GRAD_W      = 16;
    localparam int ENTRY_W     = 2 * GRAD_W;
    localparam int PT_W        = 16;
    localparam int COORD_W     = 6;
    localparam int NOISE_W     = 16;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int FIFO_DEPTH  = 16;
    localparam int LIMIT_W     = 9;

endpackage

// ----- hdl/gradient_noise_2d_unit.sv -----
// 2-d gradient noise: gradient writes and point evaluations share one request channel.
// a result is offered once its request has passed the table read, the pipeline stages
// and then the output queue; write requests give no result.
// throughput: one request per cycle while s_ready is high; four banked copies fetch the four corners at once.
// reset: synchronous active low; grid registers return to 64, queue and pipeline empty,
// gradient table contents stay undefined until written (no clearing pass).
module gradient_noise_2d_unit
    import gn2d_pkg::*;
#(
    parameter int GRID_MAX_W = 64,
    parameter int GRID_MAX_H = 64,
    parameter int FRAC_BITS  = 10
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_op,
    input  logic [COORD_W-1:0]        s_grad_row,
    input  logic [COORD_W-1:0]        s_grad_col,
    input  logic signed [GRAD_W-1:0]  s_grad_x,
    input  logic signed [GRAD_W-1:0]  s_grad_y,
    input  logic [PT_W-1:0]           s_point_x,
    input  logic [PT_W-1:0]           s_point_y,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [NOISE_W-1:0] m_noise_value,
    output logic                      m_out_of_range,

    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_AW-1:0]         paddr,
    input  logic [APB_DW-1:0]         pwdata,
    output logic [APB_DW-1:0]         prdata,
    output logic                      pready
);

    localparam int DEPTH  = GRID_MAX_W * GRID_MAX_H;
    localparam int AW     = $clog2(DEPTH);
    localparam int XW     = PT_W - FRAC_BITS;
    localparam int DW     = FRAC_BITS + 1;
    localparam int PW     = DW + GRAD_W;
    localparam int SW     = PW + 2;
    localparam int NW     = GRAD_W + 3;
    localparam int WW     = FRAC_BITS + 2;
    localparam int LW     = NW + WW;
    localparam int LSW    = LW + 2;
    localparam int PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

    localparam logic signed [SW-1:0]  DOT_HALF  = SW'(2 ** (FRAC_BITS - 1));
    localparam logic signed [LSW-1:0] LERP_HALF = LSW'(2 ** (FRAC_BITS - 1));
    localparam logic [FRAC_BITS:0]    ONE_FIX   = (FRAC_BITS + 1)'(2 ** FRAC_BITS);
    localparam logic signed [NW-1:0]  SAT_MAX   = NW'(32767);
    localparam logic signed [NW-1:0]  SAT_MIN   = NW'(-32768);

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] grid_w_reg;
    logic [CFG_W-1:0] grid_h_reg;
    logic             cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_w_reg <= CFG_W'(64);
            grid_h_reg <= CFG_W'(64);
        end else if (cfg_we) begin
            unique case (reg_idx_t'(paddr[2]))
                REG_GRID_W: grid_w_reg <= pwdata[CFG_W-1:0];
                REG_GRID_H: grid_h_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx_t'(paddr[2]))
            REG_GRID_W: prdata = APB_DW'(grid_w_reg);
            REG_GRID_H: prdata = APB_DW'(grid_h_reg);
            default:    prdata = '0;
        endcase
    end

    // ---------------- request decode ----------------
    logic                  in_acc;
    logic                  eval_acc;
    logic                  tab_we;
    logic [AW-1:0]         wr_addr;
    logic [XW-1:0]         x0;
    logic [XW-1:0]         y0;
    logic [LIMIT_W-1:0]    wlim;
    logic [LIMIT_W-1:0]    hlim;
    logic                  oor;
    logic [AW-1:0]         rd_addr [4];

    assign in_acc   = s_valid && s_ready;
    assign eval_acc = in_acc && (op_t'(s_op) == OP_EVAL);
    assign tab_we   = in_acc && (op_t'(s_op) == OP_WRITE) &&
                      (32'(s_grad_row) < GRID_MAX_H) && (32'(s_grad_col) < GRID_MAX_W);
    assign wr_addr  = AW'(32'(s_grad_row) * GRID_MAX_W + 32'(s_grad_col));

    assign x0 = s_point_x[PT_W-1:FRAC_BITS];
    assign y0 = s_point_y[PT_W-1:FRAC_BITS];

    always_comb begin
        wlim = (LIMIT_W'(grid_w_reg) < LIMIT_W'(GRID_MAX_W)) ? LIMIT_W'(grid_w_reg)
                                                             : LIMIT_W'(GRID_MAX_W);
        hlim = (LIMIT_W'(grid_h_reg) < LIMIT_W'(GRID_MAX_H)) ? LIMIT_W'(grid_h_reg)
                                                             : LIMIT_W'(GRID_MAX_H);
        oor  = (17'(x0) + 17'd1 >= 17'(wlim)) || (17'(y0) + 17'd1 >= 17'(hlim));
        // corner order: (x0,y0) (x0+1,y0) (x0,y0+1) (x0+1,y0+1)
        rd_addr[0] = AW'(32'(y0) * GRID_MAX_W + 32'(x0));
        rd_addr[1] = AW'(32'(y0) * GRID_MAX_W + 32'(x0) + 32'd1);
        rd_addr[2] = AW'((32'(y0) + 32'd1) * GRID_MAX_W + 32'(x0));
        rd_addr[3] = AW'((32'(y0) + 32'd1) * GRID_MAX_W + 32'(x0) + 32'd1);
    end

    // ---------------- gradient table, one copy per corner ----------------
    logic [ENTRY_W-1:0] gtab_mem [4][DEPTH];
    logic [ENTRY_W-1:0] rd_reg   [4];

    always_ff @(posedge aclk) begin
        for (int c = 0; c < 4; c++) begin
            if (tab_we) begin
                gtab_mem[c][wr_addr] <= {s_grad_y, s_grad_x};
            end
            rd_reg[c] <= gtab_mem[c][rd_addr[c]];
        end
    end

    // ---------------- stage 1: point fraction beside read data ----------------
    logic                 s1_valid_reg;
    logic [FRAC_BITS-1:0] s1_fx_reg;
    logic [FRAC_BITS-1:0] s1_fy_reg;
    logic                 s1_oor_reg;

    always_ff @(posedge aclk) begin
        s1_fx_reg  <= s_point_x[FRAC_BITS-1:0];
        s1_fy_reg  <= s_point_y[FRAC_BITS-1:0];
        s1_oor_reg <= oor;
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= eval_acc;
        end
    end

    // ---------------- stage 2: distance times gradient ----------------
    logic signed [DW-1:0] dx [4];
    logic signed [DW-1:0] dy [4];
    logic signed [PW-1:0] s2_px_reg [4];
    logic signed [PW-1:0] s2_py_reg [4];
    logic                 s2_valid_reg;
    logic [FRAC_BITS-1:0] s2_fx_reg;
    logic [FRAC_BITS-1:0] s2_fy_reg;
    logic                 s2_oor_reg;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            // far corner distance is frac - 1.0, which is the frac with a set sign bit
            dx[c] = $signed({(c % 2 == 1), s1_fx_reg});
            dy[c] = $signed({(c / 2 == 1), s1_fy_reg});
        end
    end

    always_ff @(posedge aclk) begin
        for (int c = 0; c < 4; c++) begin
            s2_px_reg[c] <= dx[c] * $signed(rd_reg[c][GRAD_W-1:0]);
            s2_py_reg[c] <= dy[c] * $signed(rd_reg[c][ENTRY_W-1:GRAD_W]);
        end
        s2_fx_reg  <= s1_fx_reg;
        s2_fy_reg  <= s1_fy_reg;
        s2_oor_reg <= s1_oor_reg;
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // ---------------- stage 3: dot products rounded to q14 ----------------
    logic signed [NW-1:0] s3_n_reg [4];
    logic                 s3_valid_reg;
    logic [FRAC_BITS-1:0] s3_fx_reg;
    logic [FRAC_BITS-1:0] s3_fy_reg;
    logic                 s3_oor_reg;

    always_ff @(posedge aclk) begin
        for (int c = 0; c < 4; c++) begin
            s3_n_reg[c] <= NW'((SW'(s2_px_reg[c]) + SW'(s2_py_reg[c]) + DOT_HALF)
                               >>> FRAC_BITS);
        end
        s3_fx_reg  <= s2_fx_reg;
        s3_fy_reg  <= s2_fy_reg;
        s3_oor_reg <= s2_oor_reg;
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // ---------------- stage 4: x lerp products ----------------
    logic signed [WW-1:0] wx0;
    logic signed [WW-1:0] wx1;
    logic signed [LW-1:0] s4_a_reg [2];
    logic signed [LW-1:0] s4_b_reg [2];
    logic                 s4_valid_reg;
    logic [FRAC_BITS-1:0] s4_fy_reg;
    logic                 s4_oor_reg;

    assign wx1 = $signed({2'b00, s3_fx_reg});
    assign wx0 = $signed({1'b0, ONE_FIX - {1'b0, s3_fx_reg}});

    always_ff @(posedge aclk) begin
        for (int r = 0; r < 2; r++) begin
            s4_a_reg[r] <= s3_n_reg[2*r] * wx0;
            s4_b_reg[r] <= s3_n_reg[2*r+1] * wx1;
        end
        s4_fy_reg  <= s3_fy_reg;
        s4_oor_reg <= s3_oor_reg;
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // ---------------- stage 5: x lerp rounded ----------------
    logic signed [NW-1:0] s5_ix_reg [2];
    logic                 s5_valid_reg;
    logic [FRAC_BITS-1:0] s5_fy_reg;
    logic                 s5_oor_reg;

    always_ff @(posedge aclk) begin
        for (int r = 0; r < 2; r++) begin
            s5_ix_reg[r] <= NW'((LSW'(s4_a_reg[r]) + LSW'(s4_b_reg[r]) + LERP_HALF)
                                >>> FRAC_BITS);
        end
        s5_fy_reg  <= s4_fy_reg;
        s5_oor_reg <= s4_oor_reg;
        if (!aresetn) begin
            s5_valid_reg <= 1'b0;
        end else begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // ---------------- stage 6: y lerp products ----------------
    logic signed [WW-1:0] wy0;
    logic signed [WW-1:0] wy1;
    logic signed [LW-1:0] s6_a_reg;
    logic signed [LW-1:0] s6_b_reg;
    logic                 s6_valid_reg;
    logic                 s6_oor_reg;

    assign wy1 = $signed({2'b00, s5_fy_reg});
    assign wy0 = $signed({1'b0, ONE_FIX - {1'b0, s5_fy_reg}});

    always_ff @(posedge aclk) begin
        s6_a_reg   <= s5_ix_reg[0] * wy0;
        s6_b_reg   <= s5_ix_reg[1] * wy1;
        s6_oor_reg <= s5_oor_reg;
        if (!aresetn) begin
            s6_valid_reg <= 1'b0;
        end else begin
            s6_valid_reg <= s5_valid_reg;
        end
    end

    // ---------------- final round, saturate, out of range mask ----------------
    logic signed [NW-1:0]      fin_val;
    logic signed [NOISE_W-1:0] fin_noise;

    always_comb begin
        fin_val = NW'((LSW'(s6_a_reg) + LSW'(s6_b_reg) + LERP_HALF) >>> FRAC_BITS);
        if (s6_oor_reg) begin
            fin_noise = '0;
        end else if (fin_val > SAT_MAX) begin
            fin_noise = NOISE_W'(SAT_MAX);
        end else if (fin_val < SAT_MIN) begin
            fin_noise = NOISE_W'(SAT_MIN);
        end else begin
            fin_noise = NOISE_W'(fin_val);
        end
    end

    // ---------------- output queue with credit on the input side ----------------
    logic signed [NOISE_W-1:0] fifo_noise_reg [FIFO_DEPTH];
    logic                      fifo_oor_reg   [FIFO_DEPTH];
    logic [PTR_W-1:0]          wr_ptr_reg;
    logic [PTR_W-1:0]          rd_ptr_reg;
    logic [FILL_W-1:0]         fill_reg;
    logic [FILL_W-1:0]         credit_reg;
    logic [FILL_W-1:0]         credit_next;
    logic                      push;
    logic                      pop;

    assign push    = s6_valid_reg;
    assign pop     = m_valid && m_ready;
    assign m_valid = (fill_reg != '0);
    // credit covers requests still in the pipeline plus queued results
    assign s_ready = (credit_reg < FILL_W'(FIFO_DEPTH));

    assign m_noise_value  = fifo_noise_reg[rd_ptr_reg];
    assign m_out_of_range = fifo_oor_reg[rd_ptr_reg];

    always_comb begin
        credit_next = credit_reg;
        if (eval_acc && !pop) begin
            credit_next = credit_reg + FILL_W'(1);
        end else if (!eval_acc && pop) begin
            credit_next = credit_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_noise_reg[wr_ptr_reg] <= fin_noise;
            fifo_oor_reg[wr_ptr_reg]   <= s6_oor_reg;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            credit_reg <= '0;
        end else begin
            credit_reg <= credit_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + FILL_W'(1);
            end else if (!push && pop) begin
                fill_reg <= fill_reg - FILL_W'(1);
            end
        end
    end

endmodule

// ----- tb/gn2d_tb_pkg.sv -----
`timescale 1ns / 1ps

package gn2d_tb_pkg;

    import gn2d_pkg::*;

    localparam int GRID_COLS = 64;
    localparam int GRID_ROWS = 64;
    localparam int FRAC      = 10;
    localparam longint ONE_FIX = longint'(1) << FRAC;

    typedef struct {
        op_t                      op;
        logic [COORD_W-1:0]       row;
        logic [COORD_W-1:0]       col;
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic [PT_W-1:0]          px;
        logic [PT_W-1:0]          py;
    } noise_req_t;

    typedef struct {
        logic signed [NOISE_W-1:0] noise;
        logic                      oor;
    } noise_sample_t;

    class noise_scoreboard;

        bit [ENTRY_W-1:0] grad_mem [GRID_COLS*GRID_ROWS];
        logic [CFG_W-1:0] grid_w;
        logic [CFG_W-1:0] grid_h;
        noise_sample_t    queued_samples [$];
        int               errors;

        function new();
            grid_w = CFG_W'(64);
            grid_h = CFG_W'(64);
            errors = 0;
        endfunction

        function void set_grid(reg_idx_t idx, logic [CFG_W-1:0] v);
            if (idx == REG_GRID_W) begin
                grid_w = v;
            end else begin
                grid_h = v;
            end
        endfunction

        function logic [CFG_W-1:0] grid_reg(reg_idx_t idx);
            return (idx == REG_GRID_W) ? grid_w : grid_h;
        endfunction

        // register value clamped to the table size
        function int unsigned cells_in_use(reg_idx_t idx);
            int unsigned lim;
            lim = (idx == REG_GRID_W) ? GRID_COLS : GRID_ROWS;
            return (int'(grid_reg(idx)) < lim) ? int'(grid_reg(idx)) : lim;
        endfunction

        function int pending();
            return queued_samples.size();
        endfunction

        // round half up from Q(FRAC+14) down to Q14
        local function longint round_frac(longint v);
            return (v + (longint'(1) << (FRAC - 1))) >>> FRAC;
        endfunction

        local function longint corner_dot(int unsigned col, int unsigned row,
                                          longint dx, longint dy);
            bit [ENTRY_W-1:0]         e;
            logic signed [GRAD_W-1:0] gx;
            logic signed [GRAD_W-1:0] gy;
            e  = grad_mem[row * GRID_COLS + col];
            gx = e[GRAD_W-1:0];
            gy = e[ENTRY_W-1:GRAD_W];
            return round_frac(dx * gx + dy * gy);
        endfunction

        local function longint lerp_frac(longint a0, longint a1, longint w);
            return round_frac(a0 * (ONE_FIX - w) + a1 * w);
        endfunction

        function void note_request(noise_req_t r);
            int unsigned   cx;
            int unsigned   cy;
            longint        fx;
            longint        fy;
            longint        top;
            longint        bot;
            longint        v;
            noise_sample_t s;
            if (r.op == OP_WRITE) begin
                grad_mem[int'(r.row) * GRID_COLS + int'(r.col)] = {r.gy, r.gx};
                return;
            end
            cx = int'(r.px) >> FRAC;
            cy = int'(r.py) >> FRAC;
            fx = longint'(int'(r.px) & (int'(ONE_FIX) - 1));
            fy = longint'(int'(r.py) & (int'(ONE_FIX) - 1));
            if (cx + 1 >= cells_in_use(REG_GRID_W) || cy + 1 >= cells_in_use(REG_GRID_H)) begin
                s.noise = '0;
                s.oor   = 1'b1;
            end else begin
                top = lerp_frac(corner_dot(cx, cy, fx, fy),
                                corner_dot(cx + 1, cy, fx - ONE_FIX, fy), fx);
                bot = lerp_frac(corner_dot(cx, cy + 1, fx, fy - ONE_FIX),
                                corner_dot(cx + 1, cy + 1, fx - ONE_FIX, fy - ONE_FIX), fx);
                v = lerp_frac(top, bot, fy);
                if (v > 32767) begin
                    v = 32767;
                end
                if (v < -32768) begin
                    v = -32768;
                end
                s.noise = v[NOISE_W-1:0];
                s.oor   = 1'b0;
            end
            queued_samples.insert(queued_samples.size(), s);
        endfunction

        function void check_result(logic signed [NOISE_W-1:0] noise, logic oor);
            noise_sample_t want;
            if (queued_samples.size() == 0) begin
                $error("result with no request pending: noise_value %0d out_of_range %0b",
                       noise, oor);
                errors++;
                return;
            end
            want = queued_samples.pop_front();
            if (noise !== want.noise) begin
                $error("noise_value: expected %0d, got %0d", want.noise, noise);
                errors++;
            end
            if (oor !== want.oor) begin
                $error("out_of_range: expected %0b, got %0b", want.oor, oor);
                errors++;
            end
        endfunction

    endclass

endpackage

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    import gn2d_pkg::*;
    import gn2d_tb_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 12;
    localparam int STALL_LIMIT  = 4000;

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_op;
    logic [COORD_W-1:0]        s_grad_row;
    logic [COORD_W-1:0]        s_grad_col;
    logic signed [GRAD_W-1:0]  s_grad_x;
    logic signed [GRAD_W-1:0]  s_grad_y;
    logic [PT_W-1:0]           s_point_x;
    logic [PT_W-1:0]           s_point_y;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [NOISE_W-1:0] m_noise_value;
    logic                      m_out_of_range;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_AW-1:0]         paddr;
    logic [APB_DW-1:0]         pwdata;
    logic [APB_DW-1:0]         prdata;
    logic                      pready;

    noise_scoreboard sb = new();
    bit              grad_loaded [GRID_ROWS][GRID_COLS];
    int unsigned     items_sent = 0;
    bit              send_gaps = 1'b1;
    bit              recv_gaps = 1'b1;
    bit              hold_request = 1'b0;

    gradient_noise_2d_unit #(
        .GRID_MAX_W (GRID_COLS),
        .GRID_MAX_H (GRID_ROWS),
        .FRAC_BITS  (FRAC)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_grad_row     (s_grad_row),
        .s_grad_col     (s_grad_col),
        .s_grad_x       (s_grad_x),
        .s_grad_y       (s_grad_y),
        .s_point_x      (s_point_x),
        .s_point_y      (s_point_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_noise_value  (m_noise_value),
        .m_out_of_range (m_out_of_range),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 aclk = ~aclk;

    // result side
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_noise_value, m_out_of_range);
        end
    end

    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_top: done, errors");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on demand
    initial begin
        int unsigned burst;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            burst = $urandom_range(15, 1);
            if (hold_request) begin
                hold_request = 1'b0;
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (recv_gaps && $urandom_range(2) == 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (burst - 1) @(negedge aclk);
            end else begin
                @(negedge aclk);
                m_ready <= 1'b1;
                repeat (burst - 1) @(negedge aclk);
            end
        end
    end

    function automatic logic signed [GRAD_W-1:0] pick_gradient();
        int v;
        if ($urandom_range(7) == 0) begin
            return GRAD_W'($urandom);
        end
        v = int'($urandom_range(32768)) - 16384;
        return GRAD_W'(v);
    endfunction

    // mostly points inside a small window of the grid in use, some anywhere
    function automatic logic [PT_W-1:0] pick_coord(int unsigned lim);
        int unsigned sel;
        int unsigned corner;
        int unsigned frac;
        sel  = $urandom_range(19);
        frac = $urandom_range(int'(ONE_FIX) - 1);
        if ($urandom_range(9) == 0) begin
            frac = $urandom_range(1) ? 0 : int'(ONE_FIX) - 1;
        end
        if (sel < 4 || lim < 2) begin
            return PT_W'($urandom);
        end
        if (sel < 16) begin
            corner = $urandom_range((lim - 2 < 7) ? lim - 2 : 7);
        end else begin
            corner = $urandom_range(lim - 2);
        end
        return PT_W'((corner << FRAC) | frac);
    endfunction

    task automatic drive_request(noise_req_t r);
        int unsigned gap;
        if (send_gaps && $urandom_range(3) == 0) begin
            gap = $urandom_range(15, 1);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_op       <= r.op;
        s_grad_row <= r.row;
        s_grad_col <= r.col;
        s_grad_x   <= r.gx;
        s_grad_y   <= r.gy;
        s_point_x  <= r.px;
        s_point_y  <= r.py;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(r);
        items_sent++;
    endtask

    task automatic send_write(int unsigned row, int unsigned col,
                              logic signed [GRAD_W-1:0] gx, logic signed [GRAD_W-1:0] gy);
        noise_req_t r;
        r.op  = OP_WRITE;
        r.row = COORD_W'(row);
        r.col = COORD_W'(col);
        r.gx  = gx;
        r.gy  = gy;
        r.px  = PT_W'($urandom);
        r.py  = PT_W'($urandom);
        grad_loaded[row][col] = 1'b1;
        drive_request(r);
    endtask

    // loads any corner of the cell not yet written, then evaluates
    task automatic send_eval(logic [PT_W-1:0] px, logic [PT_W-1:0] py);
        int unsigned cx;
        int unsigned cy;
        noise_req_t  r;
        cx = int'(px) >> FRAC;
        cy = int'(py) >> FRAC;
        if (cx + 1 < GRID_COLS && cy + 1 < GRID_ROWS) begin
            for (int dy = 0; dy < 2; dy++) begin
                for (int dx = 0; dx < 2; dx++) begin
                    if (!grad_loaded[cy + dy][cx + dx]) begin
                        send_write(cy + dy, cx + dx, pick_gradient(), pick_gradient());
                    end
                end
            end
        end
        r.op  = OP_EVAL;
        r.row = COORD_W'($urandom);
        r.col = COORD_W'($urandom);
        r.gx  = GRAD_W'($urandom);
        r.gy  = GRAD_W'($urandom);
        r.px  = px;
        r.py  = py;
        drive_request(r);
    endtask

    task automatic run_random(int unsigned count);
        int unsigned stop;
        stop = items_sent + count;
        while (items_sent < stop) begin
            if ($urandom_range(4) == 0) begin
                send_write($urandom_range(GRID_ROWS - 1), $urandom_range(GRID_COLS - 1),
                           pick_gradient(), pick_gradient());
            end else begin
                send_eval(pick_coord(sb.cells_in_use(REG_GRID_W)),
                          pick_coord(sb.cells_in_use(REG_GRID_H)));
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(input logic wr, input reg_idx_t idx,
                              input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_AW'(int'(idx) * 4);
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_grid_regs();
        logic [APB_DW-1:0] rd;
        apb_access(1'b0, REG_GRID_W, '0, rd);
        if (rd[CFG_W-1:0] !== sb.grid_reg(REG_GRID_W)) begin
            $error("grid_width: expected %0d, got %0d", sb.grid_reg(REG_GRID_W), rd[CFG_W-1:0]);
            sb.errors++;
        end
        apb_access(1'b0, REG_GRID_H, '0, rd);
        if (rd[CFG_W-1:0] !== sb.grid_reg(REG_GRID_H)) begin
            $error("grid_height: expected %0d, got %0d", sb.grid_reg(REG_GRID_H), rd[CFG_W-1:0]);
            sb.errors++;
        end
    endtask

    task automatic set_grid_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        logic [APB_DW-1:0] rd;
        wait_drained();
        apb_access(1'b1, REG_GRID_W, APB_DW'(w), rd);
        sb.set_grid(REG_GRID_W, w);
        apb_access(1'b1, REG_GRID_H, APB_DW'(h), rd);
        sb.set_grid(REG_GRID_H, h);
        check_grid_regs();
    endtask

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_op       = OP_WRITE;
        s_grad_row = '0;
        s_grad_col = '0;
        s_grad_x   = '0;
        s_grad_y   = '0;
        s_point_x  = '0;
        s_point_y  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        check_grid_regs();

        // extreme gradients around the first cell
        send_write(0, 0, 16'sh7fff, 16'sh7fff);
        send_write(0, 1, 16'sh8000, 16'sh8000);
        send_write(1, 0, 16'sd16384, -16'sd16384);
        send_write(1, 1, -16'sd16384, 16'sd16384);
        send_eval(16'h0000, 16'h0000);
        send_eval(16'h03ff, 16'h03ff);
        send_eval(16'h0200, 16'h0100);
        send_eval(16'h03ff, 16'h0000);
        // last cell still inside the full grid, then just past it
        send_write(63, 63, '0, '0);
        send_eval(16'hfbff, 16'hfbff);
        send_eval(16'hfc00, 16'h0000);
        send_eval(16'h0000, 16'hfc00);
        send_eval(16'hffff, 16'hffff);
        // integer point: floor must give the cell starting there
        send_eval(16'h0400, 16'h0400);
        send_write(0, 0, '0, '0);
        send_eval(16'h0155, 16'h02aa);

        set_grid_size(CFG_W'(2), CFG_W'(2));
        run_random(150);
        set_grid_size(CFG_W'(127), CFG_W'(127));
        run_random(200);
        set_grid_size(CFG_W'(0), CFG_W'(1));
        run_random(60);
        set_grid_size(CFG_W'(5), CFG_W'(40));
        run_random(200);
        set_grid_size(CFG_W'($urandom_range(64, 2)), CFG_W'($urandom_range(64, 2)));
        run_random(50);
        // long receiver hold-off while requests keep coming
        hold_request = 1'b1;
        send_gaps    = 1'b0;
        run_random(80);
        send_gaps    = 1'b1;
        run_random(120);
        set_grid_size(CFG_W'(64), CFG_W'(64));
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        run_random(250);

        wait_drained();
        if (sb.errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/gn2d_pkg.sv
hdl/gradient_noise_2d_unit.sv
tb/gn2d_tb_pkg.sv
tb/tb_top.sv
